// File: sv/size_class_block_allocator_core_macros.svh
// Assertion helpers for the size class block allocator.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, masked while in reset.
`define SCBA_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("scba: same-cycle check failed");
// Next-cycle implication, masked while in reset.
`define SCBA_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("scba: next-cycle check failed");
`else
`define SCBA_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons)
`define SCBA_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons)
`endif

`endif

// File: sv/scba_pkg.sv
package scba_pkg;

    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int DEF_NUM_CLASSES = 4;

    localparam int SIZE_W    = 32;
    localparam int HDR_W     = 16;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_W     = 7;
    localparam int CLASS_W   = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_POOLS = 4;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    localparam logic [SIZE_W-1:0] CLASS_BYTES [NUM_POOLS] = '{
        32'd64, 32'd128, 32'd256, 32'd512
    };

    localparam logic [CNT_W-1:0] CNT_RESET [NUM_POOLS] = '{
        7'd51, 7'd28, 7'd15, 7'd7
    };

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC  = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_BIG    = 3'd2,
        ST_FREED  = 3'd3,
        ST_BADHDR = 3'd4,
        ST_NULL   = 3'd5
    } status_t;

    // Configuration register indexes: one block count per pool.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCKS_CLASS0 = 2'd0,
        CFG_BLOCKS_CLASS1 = 2'd1,
        CFG_BLOCKS_CLASS2 = 2'd2,
        CFG_BLOCKS_CLASS3 = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        status_t                status;
        logic [CLASS_W-1:0]     block_class;
        logic [IDX_OUT_W-1:0]   block_index;
    } result_t;

endpackage

// File: sv/scba_ram.sv
module scba_ram
#(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/size_class_block_allocator_core.sv
// Channel   Dir  Fields (lowest bit first)                                   Handshake
// s_*       in   tuser: cmd; tdata: req_size, header_size, free_index,        s_tvalid/s_tready
//                free_null, zero pad to 56 bits
// m_*       out  tuser: status; tdata: block_class, block_index              m_tvalid/m_tready
// cfg_*     in   cfg_index (pool number), cfg_data (block count)             cfg_valid/cfg_ready
//
// A request passes the input register, then decode and list update into
// the result register; one request per clock unless m_tready stalls, cfg_ready is tied high.
// Cache the link behind each list head per pool; refill it from the link memory after a pop.
// Reset clears the list heads and link valid bits and loads the default counts at once,
// so requests are taken as soon as reset is released.
// A stall on m_tready holds the result; s_tready drops only when both registers are full.

`include "size_class_block_allocator_core_macros.svh"

module size_class_block_allocator_core
    import scba_pkg::*;
#(
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // req_size[31:0], header_size[47:32], free_index[53:48], free_null[54], zero[55]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // cmd[0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // block_class[1:0], block_index[7:2]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [STATUS_W-1:0]  m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int AW     = CLS_W + IDX_W;
    localparam int DEPTH  = NUM_CLASSES * (2 ** IDX_W);
    localparam int CMP_W  = (LINK_W > CNT_W) ? LINK_W : CNT_W;

    // Input register
    logic                  in_valid_reg;
    cmd_t                  in_cmd_reg;
    logic [SIZE_W-1:0]     in_size_reg;
    logic [HDR_W-1:0]      in_hdr_reg;
    logic [IDX_OUT_W-1:0]  in_idx_reg;
    logic                  in_null_reg;

    // Result register
    logic                  out_valid_reg;
    result_t               out_reg;
    result_t               out_next;

    // Pool state
    logic [CNT_W-1:0]      count_reg [NUM_POOLS];
    logic [LINK_W-1:0]     head_reg  [NUM_CLASSES];
    logic [LINK_W-1:0]     hnext_reg [NUM_CLASSES];
    logic [DEPTH-1:0]      vld_reg;

    // Pending refill of a head's cached link after a pop
    logic                  pend_valid_reg;
    logic [CLS_W-1:0]      pend_cls_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      rd_idx_reg;

    logic                  advance;
    logic                  proc;
    logic [CLASS_W-1:0]    alloc_cls;
    logic                  too_big;
    logic [CLASS_W-1:0]    hdr_cls;
    logic                  bad_hdr;
    logic [CLASS_W-1:0]    op_cls;
    logic                  cls_ok;
    logic [CLS_W-1:0]      ci;
    logic [CNT_W-1:0]      n_eff [NUM_POOLS];
    logic [CNT_W-1:0]      n_cur;
    logic [LINK_W-1:0]     head_cur;
    logic [LINK_W-1:0]     hnext_cur;
    logic [LINK_W-1:0]     ram_rdata;
    logic [LINK_W-1:0]     link_rd;
    logic                  pop_ok;
    logic                  push_ok;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic                  no_block_res;

    assign cfg_ready = 1'b1;

    // Advance when the result register is free or being taken this cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign proc     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= cmd_t'(s_tuser[0]);
            in_size_reg <= s_tdata[31:0];
            in_hdr_reg  <= s_tdata[47:32];
            in_idx_reg  <= s_tdata[53:48];
            in_null_reg <= s_tdata[54];
        end
    end

    // Block counts; the effective count is capped at the pool depth, and a
    // class beyond the configured number of pools counts as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_POOLS; c++)
            begin
                count_reg[c] <= CNT_RESET[c];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            count_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_POOLS; c++)
        begin
            if (c >= NUM_CLASSES)
            begin
                n_eff[c] = '0;
            end
            else if (32'(count_reg[c]) > MAX_BLOCKS)
            begin
                n_eff[c] = CNT_W'(MAX_BLOCKS);
            end
            else
            begin
                n_eff[c] = count_reg[c];
            end
        end
    end

    // Pick the smallest class that fits the request.
    always_comb
    begin
        too_big   = 1'b0;
        alloc_cls = '0;
        priority if (in_size_reg <= CLASS_BYTES[0])
        begin
            alloc_cls = 2'd0;
        end
        else if (in_size_reg <= CLASS_BYTES[1])
        begin
            alloc_cls = 2'd1;
        end
        else if (in_size_reg <= CLASS_BYTES[2])
        begin
            alloc_cls = 2'd2;
        end
        else if (in_size_reg <= CLASS_BYTES[3])
        begin
            alloc_cls = 2'd3;
        end
        else
        begin
            too_big = 1'b1;
        end
    end

    // Map a size header back onto its class.
    always_comb
    begin
        bad_hdr = 1'b0;
        hdr_cls = '0;
        unique case (in_hdr_reg)
            CLASS_BYTES[0][HDR_W-1:0]: hdr_cls = 2'd0;
            CLASS_BYTES[1][HDR_W-1:0]: hdr_cls = 2'd1;
            CLASS_BYTES[2][HDR_W-1:0]: hdr_cls = 2'd2;
            CLASS_BYTES[3][HDR_W-1:0]: hdr_cls = 2'd3;
            default:                   bad_hdr = 1'b1;
        endcase
    end

    assign op_cls = (in_cmd_reg == CMD_FREE) ? hdr_cls : alloc_cls;
    assign cls_ok = 32'(op_cls) < NUM_CLASSES;
    assign ci     = cls_ok ? CLS_W'(op_cls) : '0;
    assign n_cur  = n_eff[op_cls];

    // The link of an entry never written reads as its default value, index plus one.
    assign link_rd = rd_valid_reg ? ram_rdata : LINK_W'(rd_idx_reg) + LINK_W'(1);

    assign head_cur  = head_reg[ci];
    assign hnext_cur = (pend_valid_reg && (pend_cls_reg == ci)) ? link_rd : hnext_reg[ci];

    assign pop_ok  = proc && (in_cmd_reg == CMD_ALLOC) && !too_big
                     && (CMP_W'(head_cur) < CMP_W'(n_cur));
    assign push_ok = proc && (in_cmd_reg == CMD_FREE) && !in_null_reg && !bad_hdr
                     && (CMP_W'(in_idx_reg) < CMP_W'(n_cur));

    // Write the old head behind the freed block; read the link behind the new head.
    assign waddr = {ci, IDX_W'(in_idx_reg)};
    assign raddr = {ci, IDX_W'(hnext_cur)};

    scba_ram #(
        .WIDTH  (LINK_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_link_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (waddr),
        .wdata (head_cur),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (push_ok)
        begin
            vld_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= vld_reg[raddr];
        rd_idx_reg   <= raddr[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_cls_reg   <= '0;
        end
        else
        begin
            pend_valid_reg <= pop_ok;
            pend_cls_reg   <= ci;
        end
    end

    // Heads and cached links. Pop: advance the head, then refill the cache from the link read.
    // Push: the freed block becomes the head and the old head its link.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]  <= '0;
                hnext_reg[c] <= LINK_W'(1);
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if (pop_ok && (32'(ci) == c))
                begin
                    head_reg[c] <= hnext_cur;
                end
                else if (push_ok && (32'(ci) == c))
                begin
                    head_reg[c]  <= LINK_W'(in_idx_reg);
                    hnext_reg[c] <= head_cur;
                end
                else if (pend_valid_reg && (32'(pend_cls_reg) == c))
                begin
                    hnext_reg[c] <= link_rd;
                end
            end
        end
    end

    // Result of the request in the input register.
    always_comb
    begin
        out_next = '{status: ST_FREED, block_class: '0, block_index: '0};
        if (in_cmd_reg == CMD_ALLOC)
        begin
            if (too_big)
            begin
                out_next.status = ST_BIG;
            end
            else if (pop_ok)
            begin
                out_next.status      = ST_ALLOC;
                out_next.block_class = op_cls;
                out_next.block_index = IDX_OUT_W'(head_cur);
            end
            else
            begin
                out_next.status      = ST_EMPTY;
                out_next.block_class = op_cls;
            end
        end
        else if (in_null_reg)
        begin
            out_next.status = ST_NULL;
        end
        else if (bad_hdr)
        begin
            out_next.status = ST_BADHDR;
        end
        else
        begin
            out_next.status      = ST_FREED;
            out_next.block_class = op_cls;
            out_next.block_index = in_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.block_index, out_reg.block_class};

    // Results checked for naming no block: too big and null free.
    assign no_block_res = (m_tuser == ST_BIG) || (m_tuser == ST_NULL);

    // Never back-pressure while the result register is empty.
    `SCBA_ASSERT_IMPL(a_ready_when_out_empty, clk, rst_n, !out_valid_reg, s_tready)
    // A cache refill is only ever in flight after a successful pop.
    `SCBA_ASSERT_IMPL(a_refill_after_pop, clk, rst_n, pend_valid_reg, $past(pop_ok))
    // Every request processed shows a result in the next cycle.
    `SCBA_ASSERT_NEXT(a_proc_gives_result, clk, rst_n, proc, m_tvalid)
    // Too-big and null results carry no block.
    `SCBA_ASSERT_IMPL(a_nothing_on_big, clk, rst_n, m_tvalid && no_block_res, m_tdata == '0)

endmodule
